@@ rtl/atpr_pkg.sv @@
package atpr_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GUARD_BITS        = 8;
    localparam int TABLE_LEN         = 24;
    localparam int ANGLE_W           = 15;
    localparam int THR_W             = 14;
    localparam int Z_W               = 16;
    localparam logic signed [Z_W-1:0] HALF_PI_FX = 16'sd12868;
    localparam logic [THR_W-1:0] THR_RESET = 14'd1638;

    function automatic logic signed [Z_W-1:0] atan_entry(input int i);
        logic signed [Z_W-1:0] v;
        case (i)
            0:  v = 16'sd6434;
            1:  v = 16'sd3798;
            2:  v = 16'sd2007;
            3:  v = 16'sd1019;
            4:  v = 16'sd511;
            5:  v = 16'sd256;
            6:  v = 16'sd128;
            7:  v = 16'sd64;
            8:  v = 16'sd32;
            9:  v = 16'sd16;
            10: v = 16'sd8;
            11: v = 16'sd4;
            12: v = 16'sd2;
            13: v = 16'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // control travelling alongside each CORDIC cell
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctl;

endpackage

@@ rtl/atpr_sqrt_cell.sv @@
// One step of the restoring square root: one result bit per cell.
module atpr_sqrt_cell #(
    parameter int RAD_W = 64,
    parameter int RES_W = 32,
    parameter int STEP  = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [RAD_W-1:0] i_rem,
    input  logic [RES_W-1:0] i_root,
    output logic             o_valid,
    output logic [RAD_W-1:0] o_rem,
    output logic [RES_W-1:0] o_root
);
    localparam int SH = 2 * (RES_W - 1 - STEP);

    logic [RAD_W-1:0] trial;
    logic [RAD_W-1:0] n_rem;
    logic [RES_W-1:0] n_root;
    logic             r_valid;
    logic [RAD_W-1:0] r_rem;
    logic [RES_W-1:0] r_root;

    // (4*root + 1) at the weight of the bit under test
    always_comb begin
        trial = RAD_W'({i_root, 2'b01}) << SH;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = {i_root[RES_W-2:0], 1'b1};
        end else begin
            n_rem  = i_rem;
            n_root = {i_root[RES_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
endmodule

@@ rtl/atpr_cordic_cell.sv @@
// One CORDIC vectoring rotation.
module atpr_cordic_cell #(
    parameter int XY_W = 32,
    parameter int STEP = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  atpr_pkg::t_ctl               i_ctl,
    input  logic signed [XY_W-1:0]       i_x,
    input  logic signed [XY_W-1:0]       i_y,
    input  logic signed [atpr_pkg::Z_W-1:0] i_z,
    output atpr_pkg::t_ctl               o_ctl,
    output logic signed [XY_W-1:0]       o_x,
    output logic signed [XY_W-1:0]       o_y,
    output logic signed [atpr_pkg::Z_W-1:0] o_z
);
    localparam logic signed [atpr_pkg::Z_W-1:0] ANG = atpr_pkg::atan_entry(STEP);

    logic signed [XY_W-1:0] xs, ys;
    logic signed [XY_W-1:0] n_x, n_y;
    logic signed [atpr_pkg::Z_W-1:0] n_z;
    atpr_pkg::t_ctl r_ctl;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [atpr_pkg::Z_W-1:0] r_z;

    always_comb begin
        xs = i_x >>> STEP;
        ys = i_y >>> STEP;
        if (!i_y[XY_W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
endmodule

@@ rtl/atpr_angle_chain.sv @@
// atan2(a, sqrt(b^2+c^2)): square-root cell row, then CORDIC cell row.
module atpr_angle_chain #(
    parameter int SAMPLE_WIDTH  = atpr_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = atpr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_a,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_b,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_c,
    output logic                              o_valid,
    output logic signed [atpr_pkg::Z_W-1:0]   o_angle
);
    localparam int G      = atpr_pkg::GUARD_BITS;
    localparam int RES_W  = SAMPLE_WIDTH + G + 1;   // sqrt of radicand
    localparam int RAD_W  = 2 * RES_W;
    localparam int NST    = (CORDIC_STAGES < atpr_pkg::TABLE_LEN) ?
                            CORDIC_STAGES : atpr_pkg::TABLE_LEN;
    localparam int XY_W   = SAMPLE_WIDTH + G + 3;
    localparam int Z_W    = atpr_pkg::Z_W;

    // front: square magnitudes
    logic [SAMPLE_WIDTH-1:0]   ub, uc;
    logic [2*SAMPLE_WIDTH-1:0] ub2, uc2;
    logic [RAD_W-1:0]          r_rad;
    logic signed [XY_W-1:0]    r_n0;
    logic                      r_v0;

    assign ub = i_b[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_b) : i_b;
    assign uc = i_c[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-i_c) : i_c;
    assign ub2 = (2*SAMPLE_WIDTH)'(ub) * (2*SAMPLE_WIDTH)'(ub);
    assign uc2 = (2*SAMPLE_WIDTH)'(uc) * (2*SAMPLE_WIDTH)'(uc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
        end
        r_rad <= (RAD_W'(ub2) + RAD_W'(uc2)) << (2 * G);
        r_n0  <= XY_W'(i_a) <<< G;
    end

    logic             sv   [RES_W+1];
    logic [RAD_W-1:0] srem [RES_W+1];
    logic [RES_W-1:0] sroot[RES_W+1];
    logic signed [XY_W-1:0] sn[RES_W+1];

    assign sv[0]    = r_v0;
    assign srem[0]  = r_rad;
    assign sroot[0] = '0;
    assign sn[0]    = r_n0;

    for (genvar k = 0; k < RES_W; k++) begin : g_sqrt
        atpr_sqrt_cell #(.RAD_W(RAD_W), .RES_W(RES_W), .STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(sv[k]),
            .i_rem  (srem[k]),
            .i_root (sroot[k]),
            .o_valid(sv[k+1]),
            .o_rem  (srem[k+1]),
            .o_root (sroot[k+1])
        );
        // numerator rides alongside
        always_ff @(posedge i_clk) begin
            sn[k+1] <= sn[k];
        end
    end

    atpr_pkg::t_ctl         cctl[NST+1];
    logic signed [XY_W-1:0] cx  [NST+1];
    logic signed [XY_W-1:0] cy  [NST+1];
    logic signed [Z_W-1:0]  cz  [NST+1];

    assign cctl[0].valid = sv[RES_W];
    assign cctl[0].zero  = (sroot[RES_W] == '0) && (sn[RES_W] == '0);
    assign cx[0] = XY_W'(sroot[RES_W]);
    assign cy[0] = sn[RES_W];
    assign cz[0] = '0;

    for (genvar s = 0; s < NST; s++) begin : g_cordic
        atpr_cordic_cell #(.XY_W(XY_W), .STEP(s)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (cctl[s]),
            .i_x    (cx[s]),
            .i_y    (cy[s]),
            .i_z    (cz[s]),
            .o_ctl  (cctl[s+1]),
            .o_x    (cx[s+1]),
            .o_y    (cy[s+1]),
            .o_z    (cz[s+1])
        );
    end

    logic signed [Z_W-1:0] zc;
    always_comb begin
        if (cctl[NST].zero) begin
            zc = '0;
        end else if (cz[NST] > atpr_pkg::HALF_PI_FX) begin
            zc = atpr_pkg::HALF_PI_FX;
        end else if (cz[NST] < -atpr_pkg::HALF_PI_FX) begin
            zc = -atpr_pkg::HALF_PI_FX;
        end else begin
            zc = cz[NST];
        end
    end

    assign o_valid = cctl[NST].valid;
    assign o_angle = zc;
endmodule

@@ rtl/accel_tilt_pitch_roll_top.sv @@
// Channel   | Ports                                   | Transfer
// ----------+-----------------------------------------+--------------------------
// sample    | i_accel_x/y/z                           | start & !busy
// config    | i_cfg_data                              | i_cfg_valid & o_cfg_ready
// result    | o_pitch_angle, o_roll_angle, o_tilt_*   | o_done, one cycle
//
// One sample per cycle; busy stays low. Each sample passes the front register,
// SAMPLE_WIDTH + 9 square-root cells, min(CORDIC_STAGES, 24) CORDIC cells and the output register.
// Synchronous active-low reset clears valid bits and sets the threshold to 0.2 rad.
// The receiver cannot stall; results are taken in their strobe cycle.
module accel_tilt_pitch_roll_top #(
    parameter int SAMPLE_WIDTH  = atpr_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = atpr_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_accel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_accel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_accel_z,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [atpr_pkg::THR_W-1:0]           i_cfg_data,
    output logic                                 o_done,
    output logic signed [atpr_pkg::ANGLE_W-1:0]  o_pitch_angle,
    output logic signed [atpr_pkg::ANGLE_W-1:0]  o_roll_angle,
    output logic                                 o_tilt_left,
    output logic                                 o_tilt_right,
    output logic                                 o_tilt_up,
    output logic                                 o_tilt_down
);
    localparam int Z_W = atpr_pkg::Z_W;

    logic [atpr_pkg::THR_W-1:0] r_thr;
    logic accept, pv, rv;
    logic signed [Z_W-1:0] pitch, roll, thr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= atpr_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    atpr_angle_chain #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_a(i_accel_x), .i_b(i_accel_y), .i_c(i_accel_z),
        .o_valid(pv), .o_angle(pitch)
    );

    atpr_angle_chain #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_a(i_accel_y), .i_b(i_accel_x), .i_c(i_accel_z),
        .o_valid(rv), .o_angle(roll)
    );

    assign thr = Z_W'(r_thr);

    logic r_done;
    logic signed [atpr_pkg::ANGLE_W-1:0] r_pitch, r_roll;
    logic r_left, r_right, r_up, r_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= pv;
        end
        r_pitch <= pitch[atpr_pkg::ANGLE_W-1:0];
        r_roll  <= roll[atpr_pkg::ANGLE_W-1:0];
        r_left  <= roll >= thr;
        r_right <= roll <= -thr;
        r_up    <= pitch >= thr;
        r_down  <= pitch <= -thr;
    end

    assign o_done        = r_done;
    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;
    assign o_tilt_left   = r_left;
    assign o_tilt_right  = r_right;
    assign o_tilt_up     = r_up;
    assign o_tilt_down   = r_down;

    // both chains run in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n) pv == rv)
        else $error("pitch and roll chains out of step");
    a_pair_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_tilt_up && o_tilt_down) |-> (o_pitch_angle == '0))
        else $error("pitch flags both set on nonzero angle");
    a_pair_lr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_tilt_left && o_tilt_right) |-> (o_roll_angle == '0))
        else $error("roll flags both set on nonzero angle");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pitch_angle <= 15'sd12868 && o_pitch_angle >= -15'sd12868))
        else $error("pitch out of range");
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int SW     = 16;
    localparam int STAGES = 16;
    localparam int LAT    = 1 + (SW + 9) + STAGES + 1;
    localparam int AW     = atpr_pkg::ANGLE_W;
    localparam int TW     = atpr_pkg::THR_W;

    typedef struct {
        logic signed [AW-1:0] pitch;
        logic signed [AW-1:0] roll;
        logic                 left, right, up, down;
    } t_tilt;

    typedef struct {
        logic signed [SW-1:0] x, y, z;
        bit                   fixed;   // expected angles typed in below
        int                   pitch, roll;
    } t_row;

    localparam longint ATAN_LUT [24] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                        32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    logic                 i_clk, i_rst_n;
    logic                 start, busy;
    logic signed [SW-1:0] i_accel_x, i_accel_y, i_accel_z;
    logic                 i_cfg_valid, o_cfg_ready;
    logic [TW-1:0]        i_cfg_data;
    logic                 o_done;
    logic signed [AW-1:0] o_pitch_angle, o_roll_angle;
    logic                 o_tilt_left, o_tilt_right, o_tilt_up, o_tilt_down;

    t_tilt         tilt_q[$];
    logic [TW-1:0] thr_cfg;
    int            err_cnt;

    accel_tilt_pitch_roll_top #(.SAMPLE_WIDTH(SW), .CORDIC_STAGES(STAGES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_accel_x(i_accel_x), .i_accel_y(i_accel_y), .i_accel_z(i_accel_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_pitch_angle(o_pitch_angle), .o_roll_angle(o_roll_angle),
        .o_tilt_left(o_tilt_left), .o_tilt_right(o_tilt_right),
        .o_tilt_up(o_tilt_up), .o_tilt_down(o_tilt_down)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // atan2(a, sqrt(b^2 + c^2)) in rad * 8192, CORDIC vectoring
    function automatic logic signed [AW-1:0] tilt_angle_fx(longint a, longint b, longint c);
        longint unsigned sum, res, pw;
        longint          xr, yr, acc, xs, ys;
        b   = (b < 0) ? -b : b;
        c   = (c < 0) ? -c : c;
        sum = (b * b + c * c) << (2 * atpr_pkg::GUARD_BITS);
        res = 0;
        pw  = 64'd1 << 62;
        while (pw > sum) pw >>= 2;
        while (pw != 0) begin
            if (sum >= res + pw) begin
                sum -= res + pw;
                res  = (res >> 1) + pw;
            end else begin
                res >>= 1;
            end
            pw >>= 2;
        end
        xr  = longint'(res);
        yr  = a <<< atpr_pkg::GUARD_BITS;
        acc = 0;
        if (xr == 0 && yr == 0) return '0;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (yr >= 0) begin
                xr += ys;  yr -= xs;  acc += ATAN_LUT[i];
            end else begin
                xr -= ys;  yr += xs;  acc -= ATAN_LUT[i];
            end
        end
        if (acc > 12868) acc = 12868;
        if (acc < -12868) acc = -12868;
        return acc[AW-1:0];
    endfunction

    function automatic t_tilt tilt_flags(logic signed [AW-1:0] p, logic signed [AW-1:0] r);
        t_tilt  t;
        longint thr;
        thr     = longint'(thr_cfg);
        t.pitch = p;
        t.roll  = r;
        t.left  = longint'(r) >= thr;
        t.right = longint'(r) <= -thr;
        t.up    = longint'(p) >= thr;
        t.down  = longint'(p) <= -thr;
        return t;
    endfunction

    function automatic t_tilt predict_tilt(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                                           logic signed [SW-1:0] z);
        return tilt_flags(tilt_angle_fx(x, y, z), tilt_angle_fx(y, x, z));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_tilt e;
        if (i_rst_n && o_done) begin
            if (tilt_q.size() == 0) begin
                report_mismatch("outstanding results", 1, 0);
            end else begin
                e = tilt_q.pop_front();
                if (o_pitch_angle !== e.pitch) report_mismatch("pitch", o_pitch_angle, e.pitch);
                if (o_roll_angle !== e.roll) report_mismatch("roll", o_roll_angle, e.roll);
                if (o_tilt_left !== e.left) report_mismatch("tilt_left", o_tilt_left, e.left);
                if (o_tilt_right !== e.right) report_mismatch("tilt_right", o_tilt_right, e.right);
                if (o_tilt_up !== e.up) report_mismatch("tilt_up", o_tilt_up, e.up);
                if (o_tilt_down !== e.down) report_mismatch("tilt_down", o_tilt_down, e.down);
            end
        end
    end

    // called at a falling edge, returns at a falling edge with start still high
    task automatic send_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                               logic signed [SW-1:0] z, t_tilt want);
        start     = 1'b1;
        i_accel_x = x;
        i_accel_y = y;
        i_accel_z = z;
        do @(posedge i_clk); while (busy);
        tilt_q.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n > 0) begin
            start = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        while (tilt_q.size() != 0) @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [TW-1:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        thr_cfg = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic signed [SW-1:0] rand_axis();
        case ($urandom_range(0, 7))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3, 4:    return SW'($signed($urandom_range(0, 64)) - 32);
            default: return SW'($urandom());
        endcase
    endfunction

    t_row dir_tab[$] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, 0, 0},
        '{16'sd32767, 16'sd0, 16'sd0, 1'b0, 0, 0},
        '{-16'sd32768, 16'sd0, 16'sd0, 1'b0, 0, 0},
        '{16'sd0, 16'sd32767, 16'sd0, 1'b0, 0, 0},
        '{16'sd0, -16'sd32768, 16'sd0, 1'b0, 0, 0},
        '{16'sd0, 16'sd0, 16'sd32767, 1'b0, 0, 0},
        '{16'sd0, 16'sd0, -16'sd32768, 1'b0, 0, 0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 0, 0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 0, 0},
        '{16'sd1, 16'sd0, 16'sd0, 1'b0, 0, 0},
        '{-16'sd1, -16'sd1, 16'sd0, 1'b0, 0, 0},
        '{16'sd1000, 16'sd1000, 16'sd16384, 1'b0, 0, 0},
        '{-16'sd3300, 16'sd3300, 16'sd16384, 1'b0, 0, 0},
        '{16'sd5, -16'sd7, 16'sd3, 1'b0, 0, 0}
    };

    initial begin
        logic [TW-1:0]        thr_plan [6];
        t_row                 r;
        t_tilt                want;
        logic signed [SW-1:0] ax, ay, az;

        err_cnt     = 0;
        thr_cfg     = 14'd1638;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_accel_x   = '0;
        i_accel_y   = '0;
        i_accel_z   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows, run with the reset threshold and again with zero
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) write_threshold('0);
            foreach (dir_tab[k]) begin
                r    = dir_tab[k];
                want = r.fixed ? tilt_flags(r.pitch, r.roll) : predict_tilt(r.x, r.y, r.z);
                send_sample(r.x, r.y, r.z, want);
                idle_gap();
            end
            drain();
        end

        thr_plan = '{14'd12868, 14'd16383, 14'd1, 14'd1638, 14'h2AAA, 14'h1555};
        for (int ph = 0; ph < 6; ph++) begin
            write_threshold(ph < 4 ? thr_plan[ph] : TW'($urandom_range(0, 16383)));
            for (int n = 0; n < 270; n++) begin
                ax = rand_axis();
                ay = rand_axis();
                az = rand_axis();
                send_sample(ax, ay, az, predict_tilt(ax, ay, az));
                if (n == 135) begin
                    // let the pipeline empty completely mid-phase
                    start = 1'b0;
                    while (tilt_q.size() != 0) @(negedge i_clk);
                end else begin
                    idle_gap();
                end
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/atpr_pkg.sv
rtl/atpr_sqrt_cell.sv
rtl/atpr_cordic_cell.sv
rtl/atpr_angle_chain.sv
rtl/accel_tilt_pitch_roll_top.sv
bench/tb_top.sv
